>>> rtl/core/skt_pkg.sv
// Shared types and constants for the sorted or unsorted key table.
// Used by the channel interfaces, the storage cells, the priority tree and the top level.
package skt_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_WIDTH  = 32;
  // Field width of position, result_index and length.
  localparam int CNT_W      = 7;
  localparam int CELL_IDX_W = $clog2(CAPACITY);
  localparam int ENC_LEVELS = CELL_IDX_W;
  localparam int ENC_LEAVES = 1 << ENC_LEVELS;

  typedef enum logic [2:0] {
    CMD_ADD       = 3'd0,
    CMD_INSERT_AT = 3'd1,
    CMD_FIND      = 3'd2,
    CMD_READ_AT   = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_REMOVE_AT = 3'd5,
    CMD_CLEAR     = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_ENC,
    FSM_APPLY
  } fsm_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    cell_op_t               op;
    logic [CNT_W-1:0]       index;
    logic [KEY_WIDTH-1:0]   key;
    logic                   use_eq;
    logic [CNT_W-1:0]       count;
  } cell_ctrl_t;

endpackage

>>> rtl/core/skt_if.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on skt_pkg for the field widths.
interface skt_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    command;
  logic [skt_pkg::KEY_WIDTH-1:0] key;
  logic [skt_pkg::CNT_W-1:0]     position;

  modport source (output valid, output command, output key, output position, input ready);
  modport sink   (input valid, input command, input key, input position, output ready);
endinterface

interface skt_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [skt_pkg::CNT_W-1:0]     result_index;
  logic [skt_pkg::KEY_WIDTH-1:0] result_key;
  logic [skt_pkg::CNT_W-1:0]     length;

  modport source (output valid, output status, output result_index, output result_key,
                  output length, input ready);
  modport sink   (input valid, input status, input result_index, input result_key,
                  input length, output ready);
endinterface

>>> rtl/core/sorted_or_unsorted_key_table.sv
// Key table top level: a chain of storage cells, a priority tree and the command sequencer.
// Depends on skt_pkg, skt_if, skt_cell and skt_prio_enc.
//
// The table holds up to CAPACITY keys in a row of cells, one key per cell. Each command
// word produces exactly one result word. A command passes through the sequencer states in
// order: in IDLE the word is accepted and captured, in CMP every cell compares its key
// against the probe key in parallel, in ENC the priority tree picks the lowest flagged
// cell, and in APPLY the chain shifts by one place where a key is inserted or removed and
// the result register is loaded. No new command is accepted until the previous one has
// finished its apply step. A new command is taken while the previous result still waits
// at the output; its apply step then waits until that result is taken. Reset clears the
// key count, the mode bit, the sequencer state and the result valid flag; no clearing
// pass over the cells is needed.
module sorted_or_unsorted_key_table (
  input  logic      clk,
  input  logic      rst_n,
  skt_in_if.sink    in_word,
  skt_out_if.source out_word,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int KW = skt_pkg::KEY_WIDTH;
  localparam int CW = skt_pkg::CNT_W;

  skt_pkg::fsm_t               state_r, state_nxt;
  skt_pkg::cmd_t               cmd_r;
  logic [KW-1:0]               key_r;
  logic [CW-1:0]               pos_r;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        sorted_r;

  logic                        out_valid_r;
  skt_pkg::status_t            out_status_r;
  logic [CW-1:0]               out_index_r;
  logic [KW-1:0]               out_key_r;
  logic [CW-1:0]               out_length_r;

  skt_pkg::cell_ctrl_t         ctrl;
  skt_pkg::cell_op_t           op;
  logic [CW-1:0]               op_index;
  logic [KW-1:0]               cell_key [skt_pkg::CAPACITY];
  logic [skt_pkg::CAPACITY-1:0] match_vec;
  logic                        enc_hit;
  logic [skt_pkg::CELL_IDX_W-1:0] enc_idx;
  logic [CW-1:0]               enc_idx_ext;
  logic [CW-1:0]               rd_idx;
  logic [KW-1:0]               rd_key;
  logic                        full;
  logic                        out_free;
  logic                        accept;
  logic                        finish;

  skt_pkg::status_t            res_status;
  logic [CW-1:0]               res_index;
  logic [KW-1:0]               res_key;
  logic [CW-1:0]               res_cnt;
  skt_pkg::cell_op_t           res_op;

  assign accept      = in_word.valid && in_word.ready;
  assign out_free    = !out_valid_r || out_word.ready;
  assign full        = cnt_r >= CW'(skt_pkg::CAPACITY);
  assign enc_idx_ext = CW'(enc_idx);

  // Cell chain.
  assign ctrl.op     = op;
  assign ctrl.index  = op_index;
  assign ctrl.key    = key_r;
  assign ctrl.use_eq = (cmd_r != skt_pkg::CMD_ADD);
  assign ctrl.count  = cnt_r;

  for (genvar g = 0; g < skt_pkg::CAPACITY; g++) begin : g_cell
    logic [KW-1:0] left_k, right_k;
    if (g == 0) begin : g_first
      assign left_k = key_r;
    end else begin : g_left
      assign left_k = cell_key[g-1];
    end
    if (g == skt_pkg::CAPACITY - 1) begin : g_last
      assign right_k = cell_key[g];
    end else begin : g_right
      assign right_k = cell_key[g+1];
    end
    skt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_index (skt_pkg::CELL_IDX_W'(g)),
      .left_key   (left_k),
      .right_key  (right_k),
      .key_q      (cell_key[g]),
      .match_q    (match_vec[g])
    );
  end

  skt_prio_enc u_enc (
    .clk     (clk),
    .flags   (skt_pkg::ENC_LEAVES'(match_vec)),
    .hit_q   (enc_hit),
    .index_q (enc_idx)
  );

  // Key read at the position or at the found index, before any shift.
  assign rd_idx = (cmd_r == skt_pkg::CMD_READ_AT || cmd_r == skt_pkg::CMD_REMOVE_AT)
                  ? pos_r : enc_idx_ext;
  assign rd_key = cell_key[rd_idx[skt_pkg::CELL_IDX_W-1:0]];

  // Command decode for the apply step.
  always_comb begin
    res_status = skt_pkg::STAT_OK;
    res_index  = '0;
    res_key    = '0;
    res_cnt    = cnt_r;
    res_op     = skt_pkg::CELL_HOLD;
    case (cmd_r)
      skt_pkg::CMD_ADD: begin
        if (full) begin
          res_status = skt_pkg::STAT_FULL;
        end else begin
          res_index = (sorted_r && enc_hit) ? enc_idx_ext : cnt_r;
          res_key   = key_r;
          res_cnt   = cnt_r + CW'(1);
          res_op    = skt_pkg::CELL_INSERT;
        end
      end
      skt_pkg::CMD_INSERT_AT: begin
        if (pos_r > cnt_r) begin
          res_status = skt_pkg::STAT_RANGE;
        end else if (full) begin
          res_status = skt_pkg::STAT_FULL;
        end else begin
          res_index = pos_r;
          res_key   = key_r;
          res_cnt   = cnt_r + CW'(1);
          res_op    = skt_pkg::CELL_INSERT;
        end
      end
      skt_pkg::CMD_FIND: begin
        if (enc_hit) begin
          res_index = enc_idx_ext;
          res_key   = rd_key;
        end else begin
          res_status = skt_pkg::STAT_NOT_FOUND;
        end
      end
      skt_pkg::CMD_READ_AT: begin
        if (pos_r >= cnt_r) begin
          res_status = skt_pkg::STAT_RANGE;
        end else begin
          res_index = pos_r;
          res_key   = rd_key;
        end
      end
      skt_pkg::CMD_REMOVE: begin
        if (enc_hit) begin
          res_index = enc_idx_ext;
          res_key   = rd_key;
          res_cnt   = cnt_r - CW'(1);
          res_op    = skt_pkg::CELL_REMOVE;
        end else begin
          res_status = skt_pkg::STAT_NOT_FOUND;
        end
      end
      skt_pkg::CMD_REMOVE_AT: begin
        if (pos_r >= cnt_r) begin
          res_status = skt_pkg::STAT_RANGE;
        end else begin
          res_index = pos_r;
          res_key   = rd_key;
          res_cnt   = cnt_r - CW'(1);
          res_op    = skt_pkg::CELL_REMOVE;
        end
      end
      skt_pkg::CMD_CLEAR: begin
        res_cnt = '0;
      end
      default: begin
        res_cnt = cnt_r;
      end
    endcase
  end

  // Sequencer: next state, handshake and the chain's shift command.
  always_comb begin
    state_nxt     = state_r;
    in_word.ready = 1'b0;
    finish        = 1'b0;
    op            = skt_pkg::CELL_HOLD;
    op_index      = res_index;
    cnt_nxt       = cnt_r;
    case (state_r)
      skt_pkg::FSM_IDLE: begin
        in_word.ready = 1'b1;
        if (in_word.valid) begin
          state_nxt = skt_pkg::FSM_CMP;
        end
      end
      skt_pkg::FSM_CMP: begin
        state_nxt = skt_pkg::FSM_ENC;
      end
      skt_pkg::FSM_ENC: begin
        state_nxt = skt_pkg::FSM_APPLY;
      end
      skt_pkg::FSM_APPLY: begin
        if (out_free) begin
          finish    = 1'b1;
          op        = res_op;
          cnt_nxt   = res_cnt;
          state_nxt = skt_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = skt_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skt_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Key count and mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      sorted_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        sorted_r <= cfg_wdata;
      end
    end
  end

  // Captured command word.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= skt_pkg::cmd_t'(in_word.command);
      key_r <= in_word.key;
      pos_r <= in_word.position;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_key_r    <= res_key;
      out_length_r <= res_cnt;
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.status       = out_status_r;
  assign out_word.result_index = out_index_r;
  assign out_word.result_key   = out_key_r;
  assign out_word.length       = out_length_r;

endmodule

>>> rtl/core/skt_cell.sv
// One storage cell of the key chain: holds a key, compares it against the probe key
// and shifts with its neighbors on insert or remove. Depends on skt_pkg.
module skt_cell (
  input  logic                          clk,
  input  skt_pkg::cell_ctrl_t           ctrl,
  input  logic [skt_pkg::CELL_IDX_W-1:0] cell_index,
  input  logic [skt_pkg::KEY_WIDTH-1:0] left_key,
  input  logic [skt_pkg::KEY_WIDTH-1:0] right_key,
  output logic [skt_pkg::KEY_WIDTH-1:0] key_q,
  output logic                          match_q
);

  logic [skt_pkg::KEY_WIDTH-1:0] key_r, key_nxt;
  logic                          match_r, match_nxt;
  logic [skt_pkg::CNT_W-1:0]     my_idx;
  logic                          in_range;

  assign my_idx   = skt_pkg::CNT_W'(cell_index);
  assign in_range = my_idx < ctrl.count;

  // Compare flag: equality for lookups, not-less-than for sorted placement.
  always_comb begin
    if (ctrl.use_eq) begin
      match_nxt = in_range && (key_r == ctrl.key);
    end else begin
      match_nxt = in_range && (key_r >= ctrl.key);
    end
  end

  // Shift step: the tail moves up on insert and down on remove.
  always_comb begin
    key_nxt = key_r;
    case (ctrl.op)
      skt_pkg::CELL_INSERT: begin
        if (my_idx == ctrl.index) begin
          key_nxt = ctrl.key;
        end else if (my_idx > ctrl.index) begin
          key_nxt = left_key;
        end
      end
      skt_pkg::CELL_REMOVE: begin
        if (my_idx >= ctrl.index) begin
          key_nxt = right_key;
        end
      end
      default: begin
        key_nxt = key_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    match_r <= match_nxt;
  end

  assign key_q   = key_r;
  assign match_q = match_r;

endmodule

>>> rtl/core/skt_prio_enc.sv
// Registered priority tree: finds the lowest set flag of the cell chain.
// Depends on skt_pkg for the tree depth.
module skt_prio_enc (
  input  logic                            clk,
  input  logic [skt_pkg::ENC_LEAVES-1:0]  flags,
  output logic                            hit_q,
  output logic [skt_pkg::CELL_IDX_W-1:0]  index_q
);

  logic                           hit_lv [skt_pkg::ENC_LEVELS+1][skt_pkg::ENC_LEAVES];
  logic [skt_pkg::CELL_IDX_W-1:0] idx_lv [skt_pkg::ENC_LEVELS+1][skt_pkg::ENC_LEAVES];
  logic                           hit_r;
  logic [skt_pkg::CELL_IDX_W-1:0] index_r;

  // Each level merges pairs; the left child wins so the lowest index comes out.
  always_comb begin
    for (int l = 0; l <= skt_pkg::ENC_LEVELS; l++) begin
      for (int n = 0; n < skt_pkg::ENC_LEAVES; n++) begin
        hit_lv[l][n] = 1'b0;
        idx_lv[l][n] = '0;
      end
    end
    for (int n = 0; n < skt_pkg::ENC_LEAVES; n++) begin
      hit_lv[0][n] = flags[n];
    end
    for (int l = 1; l <= skt_pkg::ENC_LEVELS; l++) begin
      for (int n = 0; n < skt_pkg::ENC_LEAVES; n++) begin
        if (n < (skt_pkg::ENC_LEAVES >> l)) begin
          hit_lv[l][n] = hit_lv[l-1][2*n] | hit_lv[l-1][2*n+1];
          if (hit_lv[l-1][2*n]) begin
            idx_lv[l][n] = idx_lv[l-1][2*n];
          end else begin
            idx_lv[l][n] = idx_lv[l-1][2*n+1] | skt_pkg::CELL_IDX_W'(1 << (l-1));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r   <= hit_lv[skt_pkg::ENC_LEVELS][0];
    index_r <= idx_lv[skt_pkg::ENC_LEVELS][0];
  end

  assign hit_q   = hit_r;
  assign index_q = index_r;

endmodule
